// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the radix printer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ibd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix printer package
// Sizes, types, character codes and helpers shared by the printer modules.
// ---------------------------------------------------------------------------
package ibd_pkg;

   localparam int NUMBER_BITS   = 32;
   localparam int MAX_RADIX     = 62;
   localparam int CHAR_BITS     = 7;
   localparam int CHARS_PER_REG = 9;
   localparam int CHAR_REGS     = 7;
   localparam int ALPHA_SLOTS   = CHARS_PER_REG * CHAR_REGS;
   localparam int CSR_WIDTH     = CHAR_BITS * CHARS_PER_REG;
   localparam int CSR_INDEX_BITS = 3;
   localparam int DIGIT_BITS    = $clog2(ALPHA_SLOTS);
   localparam int LANE_BITS     = $clog2(NUMBER_BITS);
   localparam int COUNT_BITS    = $clog2(NUMBER_BITS + 1);

   typedef logic [CHAR_BITS-1:0]   char_type;
   typedef logic [DIGIT_BITS-1:0]  digit_type;
   typedef char_type [ALPHA_SLOTS-1:0] alphabet_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_LENGTH = CSR_INDEX_BITS'(CHAR_REGS);

   localparam char_type CH_MINUS   = 7'h2D;
   localparam char_type CH_LOWER_A = 7'h61;
   localparam char_type CH_LOWER_Z = 7'h7A;
   localparam char_type CH_UPPER_A = 7'h41;
   localparam char_type CH_UPPER_Z = 7'h5A;
   localparam char_type CH_ZERO    = 7'h30;
   localparam char_type CH_NINE    = 7'h39;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CONVERT,
      ST_LEAD,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic done;
      logic ok;
   } chk_status_type;

   function automatic logic is_alnum(input char_type c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_ZERO) && (c <= CH_NINE));
   endfunction

endpackage

// ===== rtl/ibd_alpha_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Alphabet checker
// Checks the length is 2 to 62, then scans the alphabet in use one character
// a cycle, checking each is a letter or digit and repeats none before it.
// ---------------------------------------------------------------------------
module ibd_alpha_chk (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ibd_pkg::alphabet_type  alphabet,
   input  ibd_pkg::digit_type     length,
   output ibd_pkg::chk_status_type status
);
   import ibd_pkg::*;

   logic      running_ff, running_in;
   logic      done_ff, done_in;
   logic      ok_ff, ok_in;
   logic      bad_ff, bad_in;
   digit_type idx_ff, idx_in;

   char_type  cur;
   logic      hit;
   logic      bad_next;
   logic      len_bad;

   always_comb begin
      cur = alphabet[idx_ff];
      hit = 1'b0;
      // Each slot below the current one is compared in parallel.
      for (int j = 0; j < ALPHA_SLOTS; j++) begin
         if ((DIGIT_BITS'(j) < idx_ff) && (alphabet[j] == cur)) begin
            hit = 1'b1;
         end
      end
      bad_next = bad_ff | ~is_alnum(cur) | hit;
      len_bad  = (length < DIGIT_BITS'(2)) || (length > DIGIT_BITS'(MAX_RADIX));
   end

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      ok_in      = ok_ff;
      bad_in     = bad_ff;
      idx_in     = idx_ff;
      if (start) begin
         idx_in = '0;
         bad_in = 1'b0;
         if (len_bad) begin
            done_in = 1'b1;
            ok_in   = 1'b0;
         end else begin
            running_in = 1'b1;
         end
      end else if (running_ff) begin
         bad_in = bad_next;
         if (idx_ff == length - DIGIT_BITS'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
            ok_in      = ~bad_next;
         end else begin
            idx_in = idx_ff + DIGIT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         ok_ff      <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         ok_ff      <= ok_in;
      end
      bad_ff <= bad_in;
      idx_ff <= idx_in;
   end

   assign status.done = done_ff;
   assign status.ok   = ok_ff;

endmodule

// ===== rtl/ibd_digit_conv.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix digit converter
// Takes the magnitude in one bit a cycle while shift is high, top bit first,
// and keeps it as base-radix digit cells that double and add on every bit.
// ---------------------------------------------------------------------------
module ibd_digit_conv (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               shift,
   input  logic                               bit_in,
   input  ibd_pkg::digit_type                 radix,
   input  logic [ibd_pkg::LANE_BITS-1:0]      rd_index,
   output ibd_pkg::digit_type                 rd_digit,
   output logic [ibd_pkg::COUNT_BITS-1:0]     count
);
   import ibd_pkg::*;

   digit_type [NUMBER_BITS-1:0] lanes_ff, lanes_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;

   logic [NUMBER_BITS-1:0] gen;
   logic [NUMBER_BITS-1:0] prop;
   logic [NUMBER_BITS:0]   sum;
   logic [NUMBER_BITS:0]   carry;
   logic [DIGIT_BITS:0]    dbl;
   logic [DIGIT_BITS:0]    twice;

   // A cell carries out when 2d + cin reaches the radix. That is certain when
   // 2d alone reaches it, and depends on cin when 2d is one short. The ripple
   // is then an ordinary carry chain, resolved here with one adder.
   always_comb begin
      for (int k = 0; k < NUMBER_BITS; k++) begin
         gen[k]  = {lanes_ff[k], 1'b0} >= {1'b0, radix};
         prop[k] = {lanes_ff[k], 1'b1} == {1'b0, radix};
      end
      sum   = {1'b0, gen | prop} + {1'b0, gen} + {{NUMBER_BITS{1'b0}}, bit_in};
      carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
   end

   always_comb begin
      lanes_in = lanes_ff;
      count_in = count_ff;
      dbl      = '0;
      twice    = '0;
      if (clear) begin
         lanes_in = '0;
         count_in = '0;
      end else if (shift) begin
         for (int k = 0; k < NUMBER_BITS; k++) begin
            twice = {lanes_ff[k], carry[k]};
            dbl   = carry[k+1] ? (twice - {1'b0, radix}) : twice;
            lanes_in[k] = dbl[DIGIT_BITS-1:0];
         end
         // The top significant cell moves up exactly when it carries out.
         count_in = count_ff + {{(COUNT_BITS-1){1'b0}}, carry[count_ff]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      lanes_ff <= lanes_in;
   end

   assign rd_digit = lanes_ff[rd_index];
   assign count    = count_ff;

endmodule

// ===== rtl/integer_to_base_digits.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Integer to radix text
// Prints a signed 32-bit integer as characters from a configured alphabet.
// ---------------------------------------------------------------------------
// An item is taken when start is high while busy is low. Its characters come
// out one per cycle, each shown for a single cycle with rsp_strobe high; the
// receiver cannot hold them off, so it must take every strobed character.
// A '-' leads a negative value and rsp_last marks the final digit. An item
// feeds the magnitude bit by bit, top bit first, into the digit cells, then
// locates the leading digit (the '-' is sent from that step), then sends the
// digits from the most significant down. The first item after any
// configuration write also waits for the alphabet scan, which stops at the
// length check when the length is illegal.
// With an illegal alphabet an item is taken and gives no characters.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_base_digits (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ibd_pkg::NUMBER_BITS-1:0] req_number,
   output logic                                rsp_strobe,
   output ibd_pkg::char_type                   rsp_character,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [ibd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ibd_pkg::CSR_WIDTH-1:0]       csr_wdata
);
   import ibd_pkg::*;

   state_type state_ff, state_in;

   logic [CSR_WIDTH-1:0] char_regs_ff [CHAR_REGS];
   digit_type            alpha_len_ff;

   logic [NUMBER_BITS-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [LANE_BITS-1:0]   cnt_ff, cnt_in;
   logic [LANE_BITS-1:0]   idx_ff, idx_in;
   logic                   dirty_ff, dirty_in;
   logic                   ok_ff, ok_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   char_type               rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   alphabet_type           alphabet;
   logic                   accept;
   logic                   chk_start;
   chk_status_type         chk_status;
   logic                   conv_shift;
   digit_type              conv_digit;
   logic [COUNT_BITS-1:0]  conv_count;
   logic [NUMBER_BITS-1:0] req_bits;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < CHAR_REGS; r++) begin
            char_regs_ff[r] <= '0;
         end
         alpha_len_ff <= '0;
      end else if (csr_write) begin
         if (csr_index < CSR_ALPHA_LENGTH) begin
            char_regs_ff[csr_index] <= csr_wdata;
         end else begin
            alpha_len_ff <= csr_wdata[DIGIT_BITS-1:0];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < CHAR_REGS; r++) begin
         for (int s = 0; s < CHARS_PER_REG; s++) begin
            alphabet[r*CHARS_PER_REG + s] = char_regs_ff[r][CHAR_BITS*s +: CHAR_BITS];
         end
      end
   end

   // ------------------------------------------------------------------
   // Datapath parts
   // ------------------------------------------------------------------
   ibd_alpha_chk u_chk (
      .clock  (clock),
      .reset  (reset),
      .start  (chk_start),
      .alphabet (alphabet),
      .length (alpha_len_ff),
      .status (chk_status)
   );

   ibd_digit_conv u_conv (
      .clock    (clock),
      .reset    (reset),
      .clear    (accept),
      .shift    (conv_shift),
      .bit_in   (mag_ff[NUMBER_BITS-1]),
      .radix    (alpha_len_ff),
      .rd_index (idx_ff),
      .rd_digit (conv_digit),
      .count    (conv_count)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign req_bits = req_number;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dirty_ff      <= 1'b0;
         ok_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dirty_ff      <= dirty_in;
         ok_ff         <= ok_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      dirty_in      = dirty_ff;
      ok_in         = ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = 1'b0;
      chk_start     = 1'b0;
      conv_shift    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in = req_bits[NUMBER_BITS-1];
               // The most negative value negates to itself, which read
               // unsigned is exactly its magnitude.
               mag_in = req_bits[NUMBER_BITS-1] ? (~req_bits + NUMBER_BITS'(1)) : req_bits;
               cnt_in = LANE_BITS'(NUMBER_BITS - 1);
               if (dirty_ff) begin
                  chk_start = 1'b1;
                  state_in  = ST_CHECK;
               end else if (ok_ff) begin
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CHECK: begin
            if (chk_status.done) begin
               dirty_in = 1'b0;
               ok_in    = chk_status.ok;
               state_in = chk_status.ok ? ST_CONVERT : ST_IDLE;
            end
         end
         ST_CONVERT: begin
            conv_shift = 1'b1;
            mag_in     = {mag_ff[NUMBER_BITS-2:0], 1'b0};
            cnt_in     = cnt_ff - LANE_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            // Zero still prints one digit.
            idx_in = (conv_count == '0) ? '0 : LANE_BITS'(conv_count - COUNT_BITS'(1));
            if (neg_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_char_in   = CH_MINUS;
            end
            state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            rsp_strobe_in = 1'b1;
            rsp_char_in   = alphabet[conv_digit];
            rsp_last_in   = (idx_ff == '0);
            idx_in        = idx_ff - LANE_BITS'(1);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         dirty_in = 1'b1;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_IMPLIES(a_strobe_needs_ok, clock, reset, rsp_strobe, ok_ff)
   `ASSERT_IMPLIES(a_last_ends_item, clock, reset, rsp_strobe && rsp_last, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, accept && (dirty_ff || ok_ff), busy)
   `ASSERT_IMPLIES(a_digit_in_range, clock, reset, state_ff == ST_DIGITS,
                   ({1'b0, idx_ff} < conv_count) || (idx_ff == '0))
   `ASSERT_IMPLIES(a_digit_below_radix, clock, reset, state_ff == ST_DIGITS,
                   conv_digit < alpha_len_ff)

endmodule
